### rtl/core/lpht_pkg.sv
// Shared types and constants for the linear probing hash table.
`timescale 1ns / 1ps
`default_nettype none

package lpht_pkg;

	// Field widths fixed by the interface
	localparam int unsigned KEY_W    = 31;
	localparam int unsigned CMD_W    = 2;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned SLOT_W   = 4;
	localparam int unsigned MARK_W   = 2;

	// Remainder unit: reciprocal multiply, then subtract, one step each
	localparam int unsigned MOD_STEPS = 2;
	localparam int unsigned MOD_CW    = 1;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_SEARCH = 2'd2
	} cmd_t;

	typedef enum logic [MARK_W-1:0] {
		MARK_EMPTY = 2'd0,
		MARK_USED  = 2'd1,
		MARK_GONE  = 2'd2
	} mark_t;

	typedef enum logic [STATUS_W-1:0] {
		RES_OK   = 2'd0,
		RES_MISS = 2'd1,
		RES_FULL = 2'd2
	} res_t;

	// Controller to datapath commands
	typedef struct packed {
		logic  clr_en;     // write an empty entry at the probe position
		logic  load;       // capture the incoming transaction
		logic  mod_step;   // one step of the home slot remainder
		logic  rd_en;      // read the entry at the probe position
		logic  advance;    // step to the next slot with wrap
		logic  wr_en;      // write the entry at the probe position
		mark_t wr_mark;
		logic  fin_en;     // capture the result
		res_t  fin_status;
		logic  fin_hit;    // result carries the probe position
		logic  out_load;   // move the result to the output register
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic  clr_last;
		logic  mod_last;
		logic  probe_last;
		mark_t mark;
		logic  key_match;
		logic [CMD_W-1:0] cmd;
		logic  out_free;
	} dp_sts_t;

endpackage

`default_nettype wire

### rtl/core/lpht_dp.sv
// Datapath: remainder unit, slot memory, probe counters and result registers.
`timescale 1ns / 1ps
`default_nettype none

module lpht_dp #(
	parameter int unsigned SLOTS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire lpht_pkg::ctrl_cmd_t cmd,
	output lpht_pkg::dp_sts_t        sts,
	input  wire logic [39:0]         s_tdata,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [7:0]               m_tdata
);

	localparam int unsigned PW = $clog2(SLOTS);
	localparam int unsigned EW = lpht_pkg::MARK_W + lpht_pkg::KEY_W;
	localparam int unsigned QS = lpht_pkg::KEY_W + PW;
	localparam int unsigned PRW = 2 * lpht_pkg::KEY_W + 1;

	// ceil(2^QS / SLOTS): exact floor quotient for every 31-bit key
	localparam logic [63:0] RECIP_WIDE =
		((64'd1 << QS) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
	localparam logic [lpht_pkg::KEY_W:0] RECIP = RECIP_WIDE[lpht_pkg::KEY_W:0];

	logic [lpht_pkg::CMD_W-1:0]  cmd_q;
	logic [lpht_pkg::KEY_W-1:0]  key_q;
	logic [PRW-1:0]              prod;
	logic [lpht_pkg::KEY_W-1:0]  quo_q;
	logic [lpht_pkg::MOD_CW-1:0] dig_q;
	logic [PW-1:0]               rem_next;
	logic [PW-1:0]               pos_q;
	logic [PW-1:0]               pos_wrap;
	logic [PW-1:0]               probe_q;
	logic [EW-1:0]               mem_q [SLOTS];
	logic [EW-1:0]               rd_q;
	logic [EW-1:0]               wr_data;
	logic [lpht_pkg::STATUS_W-1:0] res_status_q;
	logic [lpht_pkg::SLOT_W-1:0]   res_slot_q;
	logic [lpht_pkg::STATUS_W-1:0] out_status_q;
	logic [lpht_pkg::SLOT_W-1:0]   out_slot_q;
	logic                          out_valid_q;

	// Quotient by reciprocal multiply; remainder only needs the low bits
	assign prod     = PRW'(key_q) * PRW'(RECIP);
	assign rem_next = key_q[PW-1:0] - PW'(quo_q[PW-1:0] * PW'(SLOTS));

	assign pos_wrap = (pos_q == PW'(SLOTS-1)) ? '0 : pos_q + PW'(1);

	// Transaction capture and quotient register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= s_tdata[1:0];
			key_q <= s_tdata[32:2];
		end else if (cmd.mod_step) begin
			quo_q <= lpht_pkg::KEY_W'(prod >> QS);
		end
	end

	// Step counter, probe position and probe count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dig_q   <= '0;
			pos_q   <= '0;
			probe_q <= '0;
		end else begin
			if (cmd.load) begin
				dig_q   <= '0;
				probe_q <= '0;
			end else if (cmd.mod_step) begin
				dig_q <= dig_q + lpht_pkg::MOD_CW'(1);
				if (sts.mod_last) begin
					pos_q <= rem_next;
				end
			end else if (cmd.advance) begin
				pos_q   <= pos_wrap;
				probe_q <= probe_q + PW'(1);
			end else if (cmd.clr_en) begin
				pos_q <= pos_wrap;
			end
		end
	end

	// Slot memory: mark in the top bits, key below
	assign wr_data = cmd.clr_en ? {lpht_pkg::MARK_EMPTY, key_q} : {cmd.wr_mark, key_q};

	always_ff @(posedge clk) begin
		if (cmd.clr_en || cmd.wr_en) begin
			mem_q[pos_q] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_q <= mem_q[pos_q];
		end
	end

	// Result capture
	always_ff @(posedge clk) begin
		if (cmd.fin_en) begin
			res_status_q <= cmd.fin_status;
			res_slot_q   <= cmd.fin_hit ? lpht_pkg::SLOT_W'(pos_q) : '0;
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_slot_q   <= res_slot_q;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_slot_q, out_status_q};

	// Status back to the controller
	assign sts.clr_last   = (pos_q == PW'(SLOTS-1));
	assign sts.mod_last   = (dig_q == lpht_pkg::MOD_CW'(lpht_pkg::MOD_STEPS-1));
	assign sts.probe_last = (probe_q == PW'(SLOTS-1));
	assign sts.mark       = lpht_pkg::mark_t'(rd_q[EW-1:lpht_pkg::KEY_W]);
	assign sts.key_match  = (rd_q[lpht_pkg::KEY_W-1:0] == key_q);
	assign sts.cmd        = cmd_q;
	assign sts.out_free   = !out_valid_q || m_tready;

	// A finished result never overwrites one that was not taken
	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || m_tready))
		else $error("output register overwritten before transfer");

	// The probe count stays inside one pass over the table
	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		probe_q <= PW'(SLOTS-1))
		else $error("probe count beyond slot count");

	// The probe position stays inside the table
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PW'(SLOTS-1))
		else $error("probe position beyond slot count");

endmodule

`default_nettype wire

### rtl/core/lpht_ctrl.sv
// Controller: clearing pass, remainder, probe loop and result handoff.
`timescale 1ns / 1ps
`default_nettype none

module lpht_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire lpht_pkg::dp_sts_t sts,
	output lpht_pkg::ctrl_cmd_t    cmd
);

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_MOD   = 6'b000100,
		S_READ  = 6'b001000,
		S_CHECK = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_next;

	// Finish the probe loop with a given status
	function automatic void finish(inout lpht_pkg::ctrl_cmd_t c, inout state_t nx,
		input lpht_pkg::res_t st, input logic hit);
		c.fin_en     = 1'b1;
		c.fin_status = st;
		c.fin_hit    = hit;
		nx           = S_DONE;
	endfunction

	// Next state and command decode
	always_comb begin
		cmd        = '0;
		cmd.wr_mark    = lpht_pkg::MARK_USED;
		cmd.fin_status = lpht_pkg::RES_MISS;
		state_next = state_q;
		s_tready   = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (sts.clr_last) begin
					state_next = S_IDLE;
				end
			end
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load   = 1'b1;
					state_next = S_MOD;
				end
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
				if (sts.mod_last) begin
					state_next = S_READ;
				end
			end
			S_READ: begin
				cmd.rd_en  = 1'b1;
				state_next = S_CHECK;
			end
			S_CHECK: begin
				case (sts.cmd) inside
					lpht_pkg::CMD_INSERT: begin
						if (sts.mark == lpht_pkg::MARK_EMPTY ||
							sts.mark == lpht_pkg::MARK_GONE) begin
							cmd.wr_en   = 1'b1;
							cmd.wr_mark = lpht_pkg::MARK_USED;
							finish(cmd, state_next, lpht_pkg::RES_OK, 1'b1);
						end else if (sts.probe_last) begin
							finish(cmd, state_next, lpht_pkg::RES_FULL, 1'b0);
						end else begin
							cmd.advance = 1'b1;
							state_next  = S_READ;
						end
					end
					lpht_pkg::CMD_DELETE, lpht_pkg::CMD_SEARCH: begin
						if (sts.mark == lpht_pkg::MARK_EMPTY) begin
							finish(cmd, state_next, lpht_pkg::RES_MISS, 1'b0);
						end else if (sts.mark == lpht_pkg::MARK_USED && sts.key_match) begin
							if (sts.cmd == lpht_pkg::CMD_DELETE) begin
								cmd.wr_en   = 1'b1;
								cmd.wr_mark = lpht_pkg::MARK_GONE;
							end
							finish(cmd, state_next, lpht_pkg::RES_OK, 1'b1);
						end else if (sts.probe_last) begin
							finish(cmd, state_next, lpht_pkg::RES_MISS, 1'b0);
						end else begin
							cmd.advance = 1'b1;
							state_next  = S_READ;
						end
					end
					// unused command code: no change, not found
					default: begin
						finish(cmd, state_next, lpht_pkg::RES_MISS, 1'b0);
					end
				endcase
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_next   = S_IDLE;
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_next;
		end
	end

	// An accepted transaction always starts the remainder
	a_accept_to_mod: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == S_MOD))
		else $error("accepted transaction did not start remainder");

	// Every check follows a memory read
	a_check_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK) |-> ($past(state_q) == S_READ))
		else $error("check without a preceding read");

	// Apart from the clearing pass, table writes only happen while checking a probed entry
	a_write_in_check: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> (state_q == S_CHECK && cmd.fin_en))
		else $error("table write outside a finishing check");

endmodule

`default_nettype wire

### rtl/core/linear_probing_hash_table_top.sv
// Top level of the linear probing hash set: controller plus datapath.
//
//  channel | direction | payload                          | transaction when
//  s_*     | in        | tdata: command[1:0], key[32:2]   | s_tvalid && s_tready
//  m_*     | out       | tdata: status[1:0], slot[5:2]    | m_tvalid && m_tready
//
// One transaction at a time. Each item passes through an accept, 2 remainder steps
// (reciprocal multiply, then subtract), a memory read and then a check for each
// probed slot, and a handoff; the probe loop over the single memory port sets
// the pace.
// After reset a clearing pass writes every slot empty, with s_tready low. A
// result waits in the output register while the next transaction is
// accepted; a stalled output holds the next result back.
`timescale 1ns / 1ps
`default_nettype none

module linear_probing_hash_table_top #(
	parameter int unsigned SLOTS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // command[1:0], key[32:2], zero fill
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata    // status[1:0], slot[5:2], zero fill
);

	lpht_pkg::ctrl_cmd_t cmd;
	lpht_pkg::dp_sts_t   sts;

	// Sequencer
	lpht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Storage and arithmetic
	lpht_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

`default_nettype wire

### verif/tb_linear_probing_hash_table_top.sv
// Self-checking testbench for the linear probing hash set top level.
`timescale 1ns / 1ps

module tb_linear_probing_hash_table_top;
	import lpht_pkg::*;

	localparam int unsigned SLOTS       = 16;
	localparam int unsigned POOL_SIZE   = 24;
	localparam int unsigned RANDOM_OPS  = 800;
	localparam int unsigned PHASE_LEN   = 80;
	localparam int unsigned IDLE_PCT    = 28;
	localparam int unsigned QUIET_FROM  = 6000;
	localparam int unsigned QUIET_TO    = 12000;
	localparam int unsigned DRAIN       = 2 * SLOTS + 20;
	localparam int unsigned CYCLE_LIMIT = 400000;

	// Unused command code, not a member of cmd_t
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct {
		logic [CMD_W-1:0] cmd;
		logic [KEY_W-1:0] key;
	} hash_req_t;

	typedef struct {
		res_t              status;
		logic [SLOT_W-1:0] slot;
	} hash_result_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;

	linear_probing_hash_table_top #(
		.SLOTS(SLOTS)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	// Shadow copy of the table
	logic [KEY_W-1:0] held_key  [SLOTS];
	mark_t            held_mark [SLOTS];

	hash_req_t        pending_ops[$];
	hash_result_t     expected_results[$];
	logic [KEY_W-1:0] key_pool[POOL_SIZE];

	int unsigned cycle_count = 0;
	int unsigned fail_count  = 0;
	int unsigned n_checked   = 0;
	int unsigned n_insert    = 0;
	int unsigned n_delete    = 0;
	int unsigned n_search    = 0;
	int unsigned n_unused    = 0;
	int unsigned n_full      = 0;
	int unsigned n_miss      = 0;

	// Clock
	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Watchdog
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	// Random back-pressure, with one quiet window where both sides run flat out
	function automatic bit idle_roll();
		if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO)
			return 1'b0;
		return $urandom_range(99) < IDLE_PCT;
	endfunction

	// Apply one command to the shadow table and return the result it must give
	function automatic hash_result_t hash_set_apply(input logic [CMD_W-1:0] cmd,
			input logic [KEY_W-1:0] key);
		hash_result_t r;
		int unsigned  pos;
		bit           done;
		r.status = RES_MISS;
		r.slot   = '0;
		pos      = key % SLOTS;
		done     = 1'b0;
		case (cmd)
			CMD_INSERT: begin
				// first empty or deleted slot, no duplicate check
				n_insert++;
				r.status = RES_FULL;
				for (int unsigned n = 0; n < SLOTS; n++) begin
					if (!done && (held_mark[pos] == MARK_EMPTY || held_mark[pos] == MARK_GONE)) begin
						held_key[pos]  = key;
						held_mark[pos] = MARK_USED;
						r.status       = RES_OK;
						r.slot         = pos[SLOT_W-1:0];
						done           = 1'b1;
					end
					pos = (pos + 1) % SLOTS;
				end
			end
			CMD_DELETE, CMD_SEARCH: begin
				// skip deleted, stop at empty, match occupied only
				if (cmd == CMD_DELETE)
					n_delete++;
				else
					n_search++;
				for (int unsigned n = 0; n < SLOTS; n++) begin
					if (!done) begin
						if (held_mark[pos] == MARK_EMPTY) begin
							done = 1'b1;
						end else if (held_mark[pos] == MARK_USED && held_key[pos] == key) begin
							if (cmd == CMD_DELETE)
								held_mark[pos] = MARK_GONE;
							r.status = RES_OK;
							r.slot   = pos[SLOT_W-1:0];
							done     = 1'b1;
						end
					end
					pos = (pos + 1) % SLOTS;
				end
			end
			default: begin
				n_unused++;
			end
		endcase
		if (r.status == RES_FULL)
			n_full++;
		if (r.status == RES_MISS)
			n_miss++;
		return r;
	endfunction

	function automatic void queue_op(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key);
		hash_req_t req;
		req.cmd = cmd;
		req.key = key;
		pending_ops.push_back(req);
	endfunction

	// Driver: predict on each accepted transaction, then present the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin : drive
			hash_req_t req;
			if (s_tvalid && s_tready)
				expected_results.push_back(hash_set_apply(s_tdata[1:0], s_tdata[32:2]));
			if (!s_tvalid || s_tready) begin
				if (pending_ops.size() != 0 && !idle_roll()) begin
					req      = pending_ops.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {7'd0, req.key, req.cmd};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each result transaction with the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin : monitor
			hash_result_t want;
			if (m_tvalid && m_tready) begin
				n_checked++;
				if (expected_results.size() == 0) begin
					$error("unexpected result transaction, tdata %0h", m_tdata);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (m_tdata[1:0] !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, m_tdata[1:0]);
						fail_count++;
					end
					if (m_tdata[5:2] !== want.slot) begin
						$error("slot: expected %0d, actual %0d", want.slot, m_tdata[5:2]);
						fail_count++;
					end
					if (m_tdata[7:6] !== 2'b00) begin
						$error("zero fill: expected 0, actual %0d", m_tdata[7:6]);
						fail_count++;
					end
				end
			end
			m_tready <= !idle_roll();
		end
	end

	// Stimulus and end of run
	initial begin
		int unsigned r;
		int unsigned pick;
		bit          fill_phase;
		logic [CMD_W-1:0] cmd;
		logic [KEY_W-1:0] key;

		for (int unsigned i = 0; i < SLOTS; i++) begin
			held_key[i]  = '0;
			held_mark[i] = MARK_EMPTY;
		end

		// Keys with random upper bits; half of them crowd the wrap point
		for (int unsigned i = 0; i < POOL_SIZE; i++) begin
			if (i % 2 == 0)
				pick = $urandom_range(SLOTS - 1);
			else
				pick = (SLOTS - 2 + $urandom_range(2)) % SLOTS;
			key_pool[i] = {KEY_W'($urandom()) & 31'h7FFFFFF0} | KEY_W'(pick);
		end

		// Directed: empty table, collisions, deleted marks, wrap, full table
		queue_op(CMD_SEARCH, 31'd7);
		queue_op(CMD_DELETE, 31'd7);
		queue_op(CMD_INSERT, 31'd0);
		queue_op(CMD_INSERT, 31'h7FFFFFFF);
		queue_op(CMD_INSERT, 31'd16);
		queue_op(CMD_SEARCH, 31'd16);
		queue_op(CMD_DELETE, 31'd0);
		queue_op(CMD_SEARCH, 31'd16);
		queue_op(CMD_INSERT, 31'd32);
		queue_op(CMD_UNUSED, 31'd16);
		queue_op(CMD_INSERT, 31'd31);
		for (int unsigned i = 0; i < 12; i++)
			queue_op(CMD_INSERT, 31'(48 + 16 * i));
		queue_op(CMD_INSERT, 31'd5);
		queue_op(CMD_SEARCH, 31'd5);
		queue_op(CMD_DELETE, 31'd5);
		queue_op(CMD_SEARCH, 31'h7FFFFFFF);

		// Random: alternating drain-heavy and fill-heavy phases
		for (int unsigned i = 0; i < RANDOM_OPS; i++) begin
			fill_phase = ((i / PHASE_LEN) % 2) == 1;
			r = $urandom_range(99);
			if (r < (fill_phase ? 55 : 20))
				cmd = CMD_INSERT;
			else if (r < (fill_phase ? 70 : 60))
				cmd = CMD_DELETE;
			else if (r < 97)
				cmd = CMD_SEARCH;
			else
				cmd = CMD_UNUSED;
			if ($urandom_range(9) == 0)
				key = KEY_W'($urandom());
			else
				key = key_pool[$urandom_range(POOL_SIZE - 1)];
			queue_op(cmd, key);
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_ops.size() != 0 || s_tvalid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("Checked %0d results: %0d inserts, %0d deletes, %0d searches, %0d unused codes",
			n_checked, n_insert, n_delete, n_search, n_unused);
		$display("Outcomes seen: %0d table full, %0d not found, %0d failures",
			n_full, n_miss, fail_count);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
